### rtl/dptr_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad to pointer translator: shared definitions
// Beat types, register indexes, key codes and reset values for the block.
// ----------------------------------------------------------------------------
package dptr_pkg;

  // Input beat: one key event or one movement tick.
  typedef struct packed {
    logic       kind;
    logic [9:0] key_code;
    logic [1:0] key_value;
  } in_beat_t;

  // Result beat: one button event or one position report.
  typedef struct packed {
    logic        out_kind;
    logic [1:0]  button;
    logic [1:0]  button_value;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
  } out_beat_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TOGGLE_KEY = 3'd0,
    REG_LEFT_KEY   = 3'd1,
    REG_MIDDLE_KEY = 3'd2,
    REG_RIGHT_KEY  = 3'd3,
    REG_SPEED      = 3'd4,
    REG_SCREEN_W   = 3'd5,
    REG_SCREEN_H   = 3'd6
  } cfg_reg_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Input beat kinds and key values.
  localparam logic       KIND_KEY    = 1'b0;
  localparam logic       KIND_TICK   = 1'b1;
  localparam logic [1:0] KEY_RELEASE = 2'd0;
  localparam logic [1:0] KEY_PRESS   = 2'd1;

  // Result beat kinds and button codes.
  localparam logic       OUT_BUTTON    = 1'b0;
  localparam logic       OUT_POSITION  = 1'b1;
  localparam logic [1:0] BUTTON_LEFT   = 2'd0;
  localparam logic [1:0] BUTTON_MIDDLE = 2'd1;
  localparam logic [1:0] BUTTON_RIGHT  = 2'd2;

  // Fixed direction key codes.
  localparam logic [9:0] DIR_UP_CODE    = 10'd544;
  localparam logic [9:0] DIR_DOWN_CODE  = 10'd545;
  localparam logic [9:0] DIR_LEFT_CODE  = 10'd546;
  localparam logic [9:0] DIR_RIGHT_CODE = 10'd547;

  // Code that marks a key register as disabled.
  localparam logic [10:0] KEY_DISABLED = 11'h7FF;

  // Reset values.
  localparam logic [10:0] RST_TOGGLE_KEY = 11'd312;
  localparam logic [10:0] RST_LEFT_KEY   = 11'd311;
  localparam logic [10:0] RST_MIDDLE_KEY = KEY_DISABLED;
  localparam logic [10:0] RST_RIGHT_KEY  = KEY_DISABLED;
  localparam logic [9:0]  RST_SPEED      = 10'd10;
  localparam logic [11:0] RST_SCREEN_W   = 12'd640;
  localparam logic [11:0] RST_SCREEN_H   = 12'd480;
  localparam logic [11:0] HOME_X         = 12'd320;
  localparam logic [11:0] HOME_Y         = 12'd240;

endpackage

### rtl/dpad_to_pointer_translator.sv
// ----------------------------------------------------------------------------
// Gamepad to pointer translator
// Turns key events into button events and movement ticks into position
// reports, with a toggle key that switches pointer mode on and off.
// ----------------------------------------------------------------------------
// A result beat appears on out_valid in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the single result register stalls the
// input only while it holds a beat that the receiver is stalling.
// Reset (rst_n low, synchronous): registers back to their defaults, pointer
// mode off, no direction held, position at the home point, no result held.
module dpad_to_pointer_translator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dptr_pkg::in_beat_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output dptr_pkg::out_beat_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [dptr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [dptr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  // Configuration registers.
  logic [10:0] toggle_key_r, left_key_r, middle_key_r, right_key_r;
  logic [9:0]  speed_r;
  logic [11:0] screen_w_r, screen_h_r;

  // Translator state.
  logic        pointer_mode_r, pointer_mode_nxt;
  logic [3:0]  held_dirs_r, held_dirs_nxt;
  logic [11:0] cur_x_r, cur_x_nxt;
  logic [11:0] cur_y_r, cur_y_nxt;

  // Result register.
  logic                out_valid_r;
  dptr_pkg::out_beat_t out_data_r;
  logic                emit;
  dptr_pkg::out_beat_t emit_data;

  logic in_accept;
  logic active;
  logic toggle_hit, left_hit, middle_hit, right_hit;

  // Tick arithmetic.
  logic [11:0] spd;
  logic [11:0] y_up, y_a, y_b, x_left, x_a, x_b;
  logic [12:0] y_sum, x_sum;

  // The input waits only while a held result is being stalled.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // A disabled toggle key leaves the block in pointer mode.
  assign active = pointer_mode_r | (toggle_key_r == dptr_pkg::KEY_DISABLED);

  // A key register matches only when it is non-negative and equal to the code.
  assign toggle_hit = (toggle_key_r[10] == 1'b0) && (toggle_key_r[9:0] == in_data.key_code);
  assign left_hit   = (left_key_r[10] == 1'b0)   && (left_key_r[9:0] == in_data.key_code);
  assign middle_hit = (middle_key_r[10] == 1'b0) && (middle_key_r[9:0] == in_data.key_code);
  assign right_hit  = (right_key_r[10] == 1'b0)  && (right_key_r[9:0] == in_data.key_code);

  // Vertical then horizontal moves, each a decrement clamped at zero followed
  // by an increment clamped at the screen size.
  assign spd    = {2'b00, speed_r};
  assign y_up   = (cur_y_r > spd) ? (cur_y_r - spd) : 12'd0;
  assign y_a    = held_dirs_r[0] ? y_up : cur_y_r;
  assign y_sum  = {1'b0, y_a} + {1'b0, spd};
  assign y_b    = held_dirs_r[1] ? ((y_sum > {1'b0, screen_h_r}) ? screen_h_r : y_sum[11:0])
                                 : y_a;
  assign x_left = (cur_x_r > spd) ? (cur_x_r - spd) : 12'd0;
  assign x_a    = held_dirs_r[2] ? x_left : cur_x_r;
  assign x_sum  = {1'b0, x_a} + {1'b0, spd};
  assign x_b    = held_dirs_r[3] ? ((x_sum > {1'b0, screen_w_r}) ? screen_w_r : x_sum[11:0])
                                 : x_a;

  // Decode of one accepted beat: next state and the result, if any.
  always_comb begin
    pointer_mode_nxt       = pointer_mode_r;
    held_dirs_nxt          = held_dirs_r;
    cur_x_nxt              = cur_x_r;
    cur_y_nxt              = cur_y_r;
    emit                   = 1'b0;
    emit_data.out_kind     = dptr_pkg::OUT_BUTTON;
    emit_data.button       = dptr_pkg::BUTTON_LEFT;
    emit_data.button_value = in_data.key_value;
    emit_data.pos_x        = cur_x_r;
    emit_data.pos_y        = cur_y_r;
    if (in_accept) begin
      if (in_data.kind == dptr_pkg::KIND_KEY) begin
        priority if (toggle_hit && (in_data.key_value == dptr_pkg::KEY_PRESS)) begin
          pointer_mode_nxt = ~pointer_mode_r;
        end else if (!active) begin
          pointer_mode_nxt = pointer_mode_r;
        end else if (in_data.key_code == dptr_pkg::DIR_UP_CODE) begin
          held_dirs_nxt[0] = (in_data.key_value != dptr_pkg::KEY_RELEASE);
        end else if (in_data.key_code == dptr_pkg::DIR_DOWN_CODE) begin
          held_dirs_nxt[1] = (in_data.key_value != dptr_pkg::KEY_RELEASE);
        end else if (in_data.key_code == dptr_pkg::DIR_LEFT_CODE) begin
          held_dirs_nxt[2] = (in_data.key_value != dptr_pkg::KEY_RELEASE);
        end else if (in_data.key_code == dptr_pkg::DIR_RIGHT_CODE) begin
          held_dirs_nxt[3] = (in_data.key_value != dptr_pkg::KEY_RELEASE);
        end else if (left_hit) begin
          emit             = 1'b1;
          emit_data.button = dptr_pkg::BUTTON_LEFT;
        end else if (middle_hit) begin
          emit             = 1'b1;
          emit_data.button = dptr_pkg::BUTTON_MIDDLE;
        end else if (right_hit) begin
          emit             = 1'b1;
          emit_data.button = dptr_pkg::BUTTON_RIGHT;
        end else begin
          emit = 1'b0;
        end
      end else if (active) begin
        cur_x_nxt              = x_b;
        cur_y_nxt              = y_b;
        emit                   = 1'b1;
        emit_data.out_kind     = dptr_pkg::OUT_POSITION;
        emit_data.button       = dptr_pkg::BUTTON_LEFT;
        emit_data.button_value = dptr_pkg::KEY_RELEASE;
        emit_data.pos_x        = x_b;
        emit_data.pos_y        = y_b;
      end
    end
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_key_r <= dptr_pkg::RST_TOGGLE_KEY;
      left_key_r   <= dptr_pkg::RST_LEFT_KEY;
      middle_key_r <= dptr_pkg::RST_MIDDLE_KEY;
      right_key_r  <= dptr_pkg::RST_RIGHT_KEY;
      speed_r      <= dptr_pkg::RST_SPEED;
      screen_w_r   <= dptr_pkg::RST_SCREEN_W;
      screen_h_r   <= dptr_pkg::RST_SCREEN_H;
    end else if (cfg_we) begin
      unique case (dptr_pkg::cfg_reg_t'(cfg_addr))
        dptr_pkg::REG_TOGGLE_KEY: toggle_key_r <= cfg_wdata[10:0];
        dptr_pkg::REG_LEFT_KEY:   left_key_r   <= cfg_wdata[10:0];
        dptr_pkg::REG_MIDDLE_KEY: middle_key_r <= cfg_wdata[10:0];
        dptr_pkg::REG_RIGHT_KEY:  right_key_r  <= cfg_wdata[10:0];
        dptr_pkg::REG_SPEED:      speed_r      <= cfg_wdata[9:0];
        dptr_pkg::REG_SCREEN_W:   screen_w_r   <= cfg_wdata;
        dptr_pkg::REG_SCREEN_H:   screen_h_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pointer_mode_r <= 1'b0;
      held_dirs_r    <= 4'd0;
      cur_x_r        <= dptr_pkg::HOME_X;
      cur_y_r        <= dptr_pkg::HOME_Y;
    end else begin
      pointer_mode_r <= pointer_mode_nxt;
      held_dirs_r    <= held_dirs_nxt;
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
    end
  end

  // Result register: loads on a new result, empties once the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A tick in pointer mode always leaves a position report behind it.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_data.kind == dptr_pkg::KIND_TICK) && active
    |=> out_valid && (out_data.out_kind == dptr_pkg::OUT_POSITION))
    else $error("tick in pointer mode gave no position report");

  // Outside pointer mode nothing is reported.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !active |=> !out_valid)
    else $error("result produced outside pointer mode");

  // Key events never move the pointer.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_data.kind == dptr_pkg::KIND_KEY)
    |=> $stable(cur_x_r) && $stable(cur_y_r))
    else $error("key event moved the pointer");

  // A held result always carries the current position.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pos_x == cur_x_r) && (out_data.pos_y == cur_y_r))
    else $error("held result disagrees with the current position");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the gamepad to pointer translator
// Sends key events and movement ticks through the valid/stall input channel.
// A scoreboard predicts each button event and position report and checks
// every result beat field by field. The run covers several register
// settings, random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  // Key values that the package leaves unnamed.
  localparam logic [1:0] KEY_REPEAT = 2'd2;
  localparam logic [1:0] KEY_HELD   = 2'd3;

  // Cycles without any accepted beat or register write before giving up.
  localparam int STALL_LIMIT = 5000;
  // Length of the long receiver hold-off.
  localparam int HOLD_OFF_CYCLES = 300;

  // Predicts the translator and holds the result beats still to arrive.
  class pointer_scoreboard;
    localparam logic [3:0] HELD_UP    = 4'b0001;
    localparam logic [3:0] HELD_DOWN  = 4'b0010;
    localparam logic [3:0] HELD_LEFT  = 4'b0100;
    localparam logic [3:0] HELD_RIGHT = 4'b1000;

    logic [10:0]         toggle_key, left_key, middle_key, right_key;
    logic [9:0]          speed;
    logic [11:0]         screen_w, screen_h;
    bit                  pointer_mode;
    logic [3:0]          held_dirs;
    logic [11:0]         cur_x, cur_y;
    dptr_pkg::out_beat_t pending_beats[$];
    int                  errors;

    function new();
      toggle_key   = dptr_pkg::RST_TOGGLE_KEY;
      left_key     = dptr_pkg::RST_LEFT_KEY;
      middle_key   = dptr_pkg::RST_MIDDLE_KEY;
      right_key    = dptr_pkg::RST_RIGHT_KEY;
      speed        = dptr_pkg::RST_SPEED;
      screen_w     = dptr_pkg::RST_SCREEN_W;
      screen_h     = dptr_pkg::RST_SCREEN_H;
      pointer_mode = 1'b0;
      held_dirs    = '0;
      cur_x        = dptr_pkg::HOME_X;
      cur_y        = dptr_pkg::HOME_Y;
      errors       = 0;
    endfunction

    function void write_reg(dptr_pkg::cfg_reg_t idx, logic [11:0] value);
      case (idx)
        dptr_pkg::REG_TOGGLE_KEY: toggle_key = value[10:0];
        dptr_pkg::REG_LEFT_KEY:   left_key   = value[10:0];
        dptr_pkg::REG_MIDDLE_KEY: middle_key = value[10:0];
        dptr_pkg::REG_RIGHT_KEY:  right_key  = value[10:0];
        dptr_pkg::REG_SPEED:      speed      = value[9:0];
        dptr_pkg::REG_SCREEN_W:   screen_w   = value;
        dptr_pkg::REG_SCREEN_H:   screen_h   = value;
        default: ;
      endcase
    endfunction

    function void queue_result(logic kind, logic [1:0] btn, logic [1:0] val);
      dptr_pkg::out_beat_t r;
      r.out_kind     = kind;
      r.button       = btn;
      r.button_value = val;
      r.pos_x        = cur_x;
      r.pos_y        = cur_y;
      pending_beats.push_back(r);
    endfunction

    // Applies one accepted input beat to the predicted state.
    function void note_input(dptr_pkg::in_beat_t b);
      logic [10:0] code;
      logic [3:0]  dir_bit;
      logic [12:0] sum;
      bit          active;
      code   = {1'b0, b.key_code};
      active = pointer_mode || (toggle_key == dptr_pkg::KEY_DISABLED);
      if (b.kind == dptr_pkg::KIND_KEY) begin
        // The toggle key press wins over everything else.
        if (toggle_key != dptr_pkg::KEY_DISABLED && code == toggle_key &&
            b.key_value == dptr_pkg::KEY_PRESS) begin
          pointer_mode = !pointer_mode;
          return;
        end
        if (!active) return;
        case (b.key_code)
          dptr_pkg::DIR_UP_CODE:    dir_bit = HELD_UP;
          dptr_pkg::DIR_DOWN_CODE:  dir_bit = HELD_DOWN;
          dptr_pkg::DIR_LEFT_CODE:  dir_bit = HELD_LEFT;
          dptr_pkg::DIR_RIGHT_CODE: dir_bit = HELD_RIGHT;
          default:                  dir_bit = '0;
        endcase
        if (dir_bit != '0) begin
          if (b.key_value != dptr_pkg::KEY_RELEASE) held_dirs = held_dirs | dir_bit;
          else held_dirs = held_dirs & ~dir_bit;
          return;
        end
        if (left_key != dptr_pkg::KEY_DISABLED && code == left_key)
          queue_result(dptr_pkg::OUT_BUTTON, dptr_pkg::BUTTON_LEFT, b.key_value);
        else if (middle_key != dptr_pkg::KEY_DISABLED && code == middle_key)
          queue_result(dptr_pkg::OUT_BUTTON, dptr_pkg::BUTTON_MIDDLE, b.key_value);
        else if (right_key != dptr_pkg::KEY_DISABLED && code == right_key)
          queue_result(dptr_pkg::OUT_BUTTON, dptr_pkg::BUTTON_RIGHT, b.key_value);
        return;
      end
      if (!active) return;
      // Movement: up, down, left, right in turn, each saturating.
      if (held_dirs & HELD_UP)
        cur_y = (cur_y > {2'b00, speed}) ? cur_y - {2'b00, speed} : '0;
      if (held_dirs & HELD_DOWN) begin
        sum   = {1'b0, cur_y} + {3'b000, speed};
        cur_y = (sum > {1'b0, screen_h}) ? screen_h : sum[11:0];
      end
      if (held_dirs & HELD_LEFT)
        cur_x = (cur_x > {2'b00, speed}) ? cur_x - {2'b00, speed} : '0;
      if (held_dirs & HELD_RIGHT) begin
        sum   = {1'b0, cur_x} + {3'b000, speed};
        cur_x = (sum > {1'b0, screen_w}) ? screen_w : sum[11:0];
      end
      queue_result(dptr_pkg::OUT_POSITION, dptr_pkg::BUTTON_LEFT, dptr_pkg::KEY_RELEASE);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(dptr_pkg::out_beat_t got);
      dptr_pkg::out_beat_t exp;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = pending_beats.pop_front();
      compare_field("out_kind", exp.out_kind, got.out_kind);
      compare_field("button", exp.button, got.button);
      compare_field("button_value", exp.button_value, got.button_value);
      compare_field("pos_x", exp.pos_x, got.pos_x);
      compare_field("pos_y", exp.pos_y, got.pos_y);
    endfunction

    function void check_leftover();
      if (pending_beats.size() != 0) begin
        $error("%0d result beats never arrived", pending_beats.size());
        errors++;
      end
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  dptr_pkg::in_beat_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  dptr_pkg::out_beat_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [dptr_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [dptr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  pointer_scoreboard sb = new();

  int send_idle_pct = 23;
  int recv_idle_pct = 76;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  dpad_to_pointer_translator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic dptr_pkg::in_beat_t make_beat(logic kind, logic [9:0] code,
                                                   logic [1:0] val);
    dptr_pkg::in_beat_t b;
    b.kind      = kind;
    b.key_code  = code;
    b.key_value = val;
    return b;
  endfunction

  // Random beat, weighted towards the keys that currently do something.
  function automatic dptr_pkg::in_beat_t random_beat();
    dptr_pkg::in_beat_t b;
    int                 pick;
    pick        = $urandom_range(99);
    b.kind      = (pick < 25) ? dptr_pkg::KIND_TICK : dptr_pkg::KIND_KEY;
    b.key_value = ($urandom_range(99) < 8) ? KEY_HELD : 2'($urandom_range(2));
    if (pick < 25)
      b.key_code = 10'($urandom_range(1023));
    else if (pick < 55)
      b.key_code = dptr_pkg::DIR_UP_CODE + 10'($urandom_range(3));
    else if (pick < 75) begin
      case ($urandom_range(2))
        0:       b.key_code = sb.left_key[9:0];
        1:       b.key_code = sb.middle_key[9:0];
        default: b.key_code = sb.right_key[9:0];
      endcase
    end else if (pick < 85)
      b.key_code = sb.toggle_key[9:0];
    else if (pick < 93)
      b.key_code = 10'($urandom_range(767));
    else
      b.key_code = 10'($urandom_range(1023));
    return b;
  endfunction

  // Offers one beat, with random idle cycles first, until it is accepted.
  task automatic push_beat(dptr_pkg::in_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
  endtask

  task automatic send(logic kind, logic [9:0] code, logic [1:0] val);
    push_beat(make_beat(kind, code, val));
  endtask

  // Waits until every expected beat is out and the pipeline has settled.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(dptr_pkg::cfg_reg_t idx, int value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value[11:0];
    @(posedge clk);
    sb.write_reg(idx, value[11:0]);
  endtask

  task automatic configure(int tog, int lft, int mid, int rgt, int spd,
                           int w, int h);
    drain();
    set_reg(dptr_pkg::REG_TOGGLE_KEY, tog);
    set_reg(dptr_pkg::REG_LEFT_KEY, lft);
    set_reg(dptr_pkg::REG_MIDDLE_KEY, mid);
    set_reg(dptr_pkg::REG_RIGHT_KEY, rgt);
    set_reg(dptr_pkg::REG_SPEED, spd);
    set_reg(dptr_pkg::REG_SCREEN_W, w);
    set_reg(dptr_pkg::REG_SCREEN_H, h);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sends the given number of random beats.
  task automatic run_random(int count);
    repeat (count) push_beat(random_beat());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats with the reset settings: mode off, then on, off and on again.
    send(dptr_pkg::KIND_TICK, 10'd0, dptr_pkg::KEY_RELEASE);
    send(dptr_pkg::KIND_KEY, 10'd311, dptr_pkg::KEY_PRESS);
    send(dptr_pkg::KIND_KEY, dptr_pkg::DIR_UP_CODE, dptr_pkg::KEY_PRESS);
    send(dptr_pkg::KIND_KEY, 10'd312, KEY_REPEAT);
    send(dptr_pkg::KIND_KEY, 10'd312, dptr_pkg::KEY_PRESS);
    send(dptr_pkg::KIND_KEY, 10'd312, dptr_pkg::KEY_RELEASE);
    send(dptr_pkg::KIND_TICK, 10'd1023, KEY_HELD);
    send(dptr_pkg::KIND_KEY, 10'd311, dptr_pkg::KEY_PRESS);
    send(dptr_pkg::KIND_KEY, 10'd311, KEY_HELD);
    send(dptr_pkg::KIND_KEY, 10'd311, dptr_pkg::KEY_RELEASE);
    send(dptr_pkg::KIND_KEY, dptr_pkg::DIR_UP_CODE, dptr_pkg::KEY_PRESS);
    send(dptr_pkg::KIND_KEY, dptr_pkg::DIR_LEFT_CODE, KEY_HELD);
    send(dptr_pkg::KIND_TICK, 10'd0, dptr_pkg::KEY_RELEASE);
    send(dptr_pkg::KIND_KEY, 10'd0, dptr_pkg::KEY_PRESS);
    send(dptr_pkg::KIND_KEY, 10'd1023, KEY_REPEAT);
    send(dptr_pkg::KIND_KEY, 10'd312, dptr_pkg::KEY_PRESS);
    send(dptr_pkg::KIND_TICK, 10'd0, dptr_pkg::KEY_RELEASE);
    send(dptr_pkg::KIND_KEY, dptr_pkg::DIR_UP_CODE, dptr_pkg::KEY_RELEASE);
    send(dptr_pkg::KIND_KEY, 10'd312, dptr_pkg::KEY_PRESS);
    send(dptr_pkg::KIND_TICK, 10'd0, dptr_pkg::KEY_RELEASE);
    send(dptr_pkg::KIND_KEY, dptr_pkg::DIR_DOWN_CODE, dptr_pkg::KEY_PRESS);
    send(dptr_pkg::KIND_KEY, dptr_pkg::DIR_RIGHT_CODE, KEY_REPEAT);
    send(dptr_pkg::KIND_KEY, dptr_pkg::DIR_LEFT_CODE, dptr_pkg::KEY_RELEASE);
    send(dptr_pkg::KIND_TICK, 10'd0, dptr_pkg::KEY_RELEASE);
    send(dptr_pkg::KIND_KEY, 10'd311, KEY_REPEAT);

    // Large screen and a button key hidden behind a direction key.
    configure(767, 0, 545, 100, 37, 4095, 4095);
    run_random(256);

    // Toggle disabled, tiny screen, fastest speed.
    send_idle_pct = 76;
    recv_idle_pct = 23;
    configure(-1, -1, 767, 0, 1023, 1, 1);
    run_random(256);

    // No idling; a long receiver hold-off fills the block.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(0, 311, 312, 313, 1, 4095, 17);
    hold_requests++;
    run_random(256);

    // Toggle on the up key and no movement at all.
    configure(544, 767, -1, -1, 0, 640, 480);
    run_random(256);

    drain();
    sb.check_leftover();
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
rtl/dptr_pkg.sv
rtl/dpad_to_pointer_translator.sv
sim/testbench.sv
